@@ hdl/itrn_pkg.sv @@
// Shared types, constants and lookup functions for the integer to Roman numeral block.
// Holds the control-store program, the digit-split constants and the letter table.
// No dependencies.
package itrn_pkg;

  localparam int VALUE_W  = 12;
  localparam int SYMBOL_W = 8;
  localparam int STEP_W   = 4;
  localparam int LEVEL_W  = 2;
  localparam int DIGIT_W  = 4;
  localparam int CNT_W    = 2;
  localparam int PROD_W   = 25;

  localparam logic [VALUE_W-1:0] VALUE_MAX = 12'd3999;
  localparam logic [LEVEL_W-1:0] LEVEL_THOUSANDS = 2'd3;

  // ASCII letters
  localparam logic [SYMBOL_W-1:0] CHR_I = 8'h49;
  localparam logic [SYMBOL_W-1:0] CHR_V = 8'h56;
  localparam logic [SYMBOL_W-1:0] CHR_X = 8'h58;
  localparam logic [SYMBOL_W-1:0] CHR_L = 8'h4C;
  localparam logic [SYMBOL_W-1:0] CHR_C = 8'h43;
  localparam logic [SYMBOL_W-1:0] CHR_D = 8'h44;
  localparam logic [SYMBOL_W-1:0] CHR_M = 8'h4D;

  // Datapath operations
  localparam logic [2:0] OP_NOP   = 3'd0;
  localparam logic [2:0] OP_SPLIT = 3'd1;
  localparam logic [2:0] OP_CLASS = 3'd2;
  localparam logic [2:0] OP_EMIT  = 3'd3;
  localparam logic [2:0] OP_LOOP  = 3'd4;
  localparam logic [2:0] OP_FIN   = 3'd5;

  // Letter select within a digit position
  localparam logic [1:0] SEL_ONE  = 2'd0;
  localparam logic [1:0] SEL_FIVE = 2'd1;
  localparam logic [1:0] SEL_TEN  = 2'd2;

  // Jump kinds
  localparam logic [2:0] JMP_SEQ   = 3'd0;
  localparam logic [2:0] JMP_CLASS = 3'd1;
  localparam logic [2:0] JMP_LOOP  = 3'd2;
  localparam logic [2:0] JMP_DIGIT = 3'd3;
  localparam logic [2:0] JMP_END   = 3'd4;

  // Digit classes
  localparam logic [1:0] CLS_LOW  = 2'd0;
  localparam logic [1:0] CLS_FOUR = 2'd1;
  localparam logic [1:0] CLS_HIGH = 2'd2;
  localparam logic [1:0] CLS_NINE = 2'd3;

  // Program addresses
  localparam logic [STEP_W-1:0] ADDR_SPLIT  = 4'd0;
  localparam logic [STEP_W-1:0] ADDR_CLASS  = 4'd1;
  localparam logic [STEP_W-1:0] ADDR_NINE   = 4'd2;
  localparam logic [STEP_W-1:0] ADDR_NINE_B = 4'd3;
  localparam logic [STEP_W-1:0] ADDR_HIGH   = 4'd4;
  localparam logic [STEP_W-1:0] ADDR_FOUR   = 4'd5;
  localparam logic [STEP_W-1:0] ADDR_FOUR_B = 4'd6;
  localparam logic [STEP_W-1:0] ADDR_LOOP   = 4'd7;
  localparam logic [STEP_W-1:0] ADDR_FIN    = 4'd8;

  typedef struct packed {
    logic [2:0]        op;
    logic [1:0]        sel;
    logic [2:0]        jmp;
    logic [STEP_W-1:0] nxt;
  } uword_t;

  typedef struct packed {
    logic   busy;
    logic   fire;
    uword_t word;
  } ctrl_t;

  typedef struct packed {
    logic [1:0] dclass;
    logic       cnt_zero;
    logic       level_zero;
    logic       hold;
  } status_t;

  // Control store
  function automatic uword_t urom(input logic [STEP_W-1:0] addr);
    uword_t w;
    w = '{op: OP_NOP, sel: SEL_ONE, jmp: JMP_END, nxt: ADDR_SPLIT};
    case (addr)
      ADDR_SPLIT:  w = '{op: OP_SPLIT, sel: SEL_ONE,  jmp: JMP_SEQ,   nxt: ADDR_CLASS};
      ADDR_CLASS:  w = '{op: OP_CLASS, sel: SEL_ONE,  jmp: JMP_CLASS, nxt: ADDR_LOOP};
      ADDR_NINE:   w = '{op: OP_EMIT,  sel: SEL_ONE,  jmp: JMP_SEQ,   nxt: ADDR_NINE_B};
      ADDR_NINE_B: w = '{op: OP_EMIT,  sel: SEL_TEN,  jmp: JMP_DIGIT, nxt: ADDR_SPLIT};
      ADDR_HIGH:   w = '{op: OP_EMIT,  sel: SEL_FIVE, jmp: JMP_SEQ,   nxt: ADDR_LOOP};
      ADDR_FOUR:   w = '{op: OP_EMIT,  sel: SEL_ONE,  jmp: JMP_SEQ,   nxt: ADDR_FOUR_B};
      ADDR_FOUR_B: w = '{op: OP_EMIT,  sel: SEL_FIVE, jmp: JMP_DIGIT, nxt: ADDR_SPLIT};
      ADDR_LOOP:   w = '{op: OP_LOOP,  sel: SEL_ONE,  jmp: JMP_LOOP,  nxt: ADDR_SPLIT};
      ADDR_FIN:    w = '{op: OP_FIN,   sel: SEL_ONE,  jmp: JMP_END,   nxt: ADDR_SPLIT};
      default:     w = '{op: OP_FIN,   sel: SEL_ONE,  jmp: JMP_END,   nxt: ADDR_SPLIT};
    endcase
    return w;
  endfunction

  // Reciprocal of the position weight, scaled by 2**rshift; exact over each position's range
  function automatic logic [12:0] recip(input logic [LEVEL_W-1:0] level);
    logic [12:0] r;
    case (level)
      2'd3:    r = 13'd4195;
      2'd2:    r = 13'd41;
      2'd1:    r = 13'd103;
      default: r = 13'd1;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] rshift(input logic [LEVEL_W-1:0] level);
    logic [4:0] s;
    case (level)
      2'd3:    s = 5'd22;
      2'd2:    s = 5'd12;
      2'd1:    s = 5'd10;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

  // Digit times the position weight
  function automatic logic [VALUE_W-1:0] multiple(input logic [LEVEL_W-1:0] level,
                                                  input logic [DIGIT_W-1:0] digit);
    logic [VALUE_W-1:0] m;
    case (level)
      2'd3:    m = VALUE_W'(digit) * 12'd1000;
      2'd2:    m = VALUE_W'(digit) * 12'd100;
      2'd1:    m = VALUE_W'(digit) * 12'd10;
      default: m = VALUE_W'(digit);
    endcase
    return m;
  endfunction

  function automatic logic [SYMBOL_W-1:0] letter(input logic [LEVEL_W-1:0] level,
                                                 input logic [1:0] sel);
    logic [SYMBOL_W-1:0] c;
    case ({level, sel})
      {2'd2, SEL_ONE}:  c = CHR_C;
      {2'd2, SEL_FIVE}: c = CHR_D;
      {2'd2, SEL_TEN}:  c = CHR_M;
      {2'd1, SEL_ONE}:  c = CHR_X;
      {2'd1, SEL_FIVE}: c = CHR_L;
      {2'd1, SEL_TEN}:  c = CHR_C;
      {2'd0, SEL_ONE}:  c = CHR_I;
      {2'd0, SEL_FIVE}: c = CHR_V;
      {2'd0, SEL_TEN}:  c = CHR_X;
      default:          c = CHR_M;
    endcase
    return c;
  endfunction

endpackage

@@ hdl/itrn_if.sv @@
// Valid/ready channel interfaces for the integer to Roman numeral block.
// Depends on itrn_pkg for field widths.
interface itrn_in_if;
  logic                           valid;
  logic                           ready;
  logic [itrn_pkg::VALUE_W-1:0]   value;
  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface itrn_out_if;
  logic                           valid;
  logic                           ready;
  logic [itrn_pkg::SYMBOL_W-1:0]  symbol;
  logic                           last;
  modport source (output valid, output symbol, output last, input ready);
  modport sink (input valid, input symbol, input last, output ready);
endinterface

@@ hdl/itrn_seq.sv @@
// Step counter and control store of the numeral sequencer.
// Depends on itrn_pkg (program, control and status structs).
module itrn_seq (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  itrn_pkg::status_t  status,
  output itrn_pkg::ctrl_t    ctrl
);

  logic                         busy;
  logic [itrn_pkg::STEP_W-1:0]  step;
  logic [itrn_pkg::STEP_W-1:0]  step_next;
  itrn_pkg::uword_t             word;
  logic                         fire;

  assign word = itrn_pkg::urom(step);
  assign fire = busy && !status.hold;

  always_comb begin
    step_next = step;
    case (word.jmp)
      itrn_pkg::JMP_SEQ: begin
        step_next = word.nxt;
      end
      itrn_pkg::JMP_CLASS: begin
        case (status.dclass)
          itrn_pkg::CLS_NINE: step_next = itrn_pkg::ADDR_NINE;
          itrn_pkg::CLS_HIGH: step_next = itrn_pkg::ADDR_HIGH;
          itrn_pkg::CLS_FOUR: step_next = itrn_pkg::ADDR_FOUR;
          default:            step_next = itrn_pkg::ADDR_LOOP;
        endcase
      end
      itrn_pkg::JMP_LOOP: begin
        if (!status.cnt_zero) step_next = step;
        else if (status.level_zero) step_next = itrn_pkg::ADDR_FIN;
        else step_next = itrn_pkg::ADDR_SPLIT;
      end
      itrn_pkg::JMP_DIGIT: begin
        step_next = status.level_zero ? itrn_pkg::ADDR_FIN : itrn_pkg::ADDR_SPLIT;
      end
      default: begin
        step_next = step;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= itrn_pkg::ADDR_SPLIT;
    end else if (start) begin
      busy <= 1'b1;
      step <= itrn_pkg::ADDR_SPLIT;
    end else if (fire) begin
      step <= step_next;
      if (word.op == itrn_pkg::OP_FIN) busy <= 1'b0;
    end
  end

  assign ctrl.busy = busy;
  assign ctrl.fire = fire;
  assign ctrl.word = word;

endmodule

@@ hdl/itrn_dpath.sv @@
// Datapath of the numeral block: digit split, letter run counter and output stages.
// Depends on itrn_pkg and the itrn_out_if channel interface.
module itrn_dpath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [itrn_pkg::VALUE_W-1:0]  value,
  input  itrn_pkg::ctrl_t               ctrl,
  output itrn_pkg::status_t             status,
  itrn_out_if.source                    numeral
);

  logic [itrn_pkg::VALUE_W-1:0]   rem;
  logic [itrn_pkg::LEVEL_W-1:0]   level;
  logic [itrn_pkg::DIGIT_W-1:0]   digit;
  logic [itrn_pkg::CNT_W-1:0]     cnt;
  logic [itrn_pkg::SYMBOL_W-1:0]  pend_sym;
  logic                           pend_valid;
  logic [itrn_pkg::SYMBOL_W-1:0]  out_sym;
  logic                           out_last;
  logic                           out_valid;

  logic [itrn_pkg::PROD_W-1:0]    prod;
  logic [itrn_pkg::PROD_W-1:0]    prod_sh;
  logic [itrn_pkg::DIGIT_W-1:0]   digit_q;
  logic                           out_free;
  logic                           needs_out;
  logic                           cnt_zero;
  logic                           level_zero;
  logic                           emit;
  logic                           digit_end;
  logic                           finish;
  logic [itrn_pkg::SYMBOL_W-1:0]  cur_letter;
  logic [1:0]                     dclass;

  // Quotient of the current position by reciprocal multiply
  assign prod    = itrn_pkg::PROD_W'(rem) * itrn_pkg::PROD_W'(itrn_pkg::recip(level));
  assign prod_sh = prod >> itrn_pkg::rshift(level);
  assign digit_q = prod_sh[itrn_pkg::DIGIT_W-1:0];

  assign cnt_zero   = (cnt == '0);
  assign level_zero = (level == '0);
  assign out_free   = !out_valid || numeral.ready;
  assign needs_out  = (ctrl.word.op == itrn_pkg::OP_EMIT) ||
                      (ctrl.word.op == itrn_pkg::OP_LOOP) ||
                      (ctrl.word.op == itrn_pkg::OP_FIN);
  assign cur_letter = itrn_pkg::letter(level, ctrl.word.sel);

  assign emit      = ctrl.fire && ((ctrl.word.op == itrn_pkg::OP_EMIT) ||
                     ((ctrl.word.op == itrn_pkg::OP_LOOP) && !cnt_zero));
  assign digit_end = ctrl.fire && ((ctrl.word.jmp == itrn_pkg::JMP_DIGIT) ||
                     ((ctrl.word.op == itrn_pkg::OP_LOOP) && cnt_zero));
  assign finish    = ctrl.fire && (ctrl.word.op == itrn_pkg::OP_FIN);

  always_comb begin
    if (digit == 4'd9) dclass = itrn_pkg::CLS_NINE;
    else if (digit >= 4'd5) dclass = itrn_pkg::CLS_HIGH;
    else if (digit == 4'd4) dclass = itrn_pkg::CLS_FOUR;
    else dclass = itrn_pkg::CLS_LOW;
  end
  assign status.dclass     = dclass;
  assign status.cnt_zero   = cnt_zero;
  assign status.level_zero = level_zero;
  assign status.hold       = ctrl.busy && needs_out && !out_free;

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (emit) pend_valid <= 1'b1;
      else if (finish) pend_valid <= 1'b0;
      if ((emit && pend_valid) || finish) out_valid <= 1'b1;
      else if (numeral.ready) out_valid <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= value;
      level <= itrn_pkg::LEVEL_THOUSANDS;
    end
    if (ctrl.fire && (ctrl.word.op == itrn_pkg::OP_SPLIT)) digit <= digit_q;
    if (ctrl.fire && (ctrl.word.op == itrn_pkg::OP_CLASS)) begin
      rem <= rem - itrn_pkg::multiple(level, digit);
      cnt <= (digit >= 4'd5) ? itrn_pkg::CNT_W'(digit - 4'd5) : itrn_pkg::CNT_W'(digit);
    end
    if (ctrl.fire && (ctrl.word.op == itrn_pkg::OP_LOOP) && !cnt_zero) cnt <= cnt - 2'd1;
    if (digit_end && !level_zero) level <= level - 2'd1;
    if (emit) pend_sym <= cur_letter;
    if (emit && pend_valid) begin
      out_sym  <= pend_sym;
      out_last <= 1'b0;
    end else if (finish) begin
      out_sym  <= pend_sym;
      out_last <= 1'b1;
    end
  end

  assign numeral.valid  = out_valid;
  assign numeral.symbol = out_sym;
  assign numeral.last   = out_last;

endmodule

@@ hdl/integer_to_roman_numeral.sv @@
// Integer to Roman numeral converter, top level.
// Depends on itrn_pkg, itrn_if (channels), itrn_seq and itrn_dpath.
//
// number  : sink channel; one transfer carries value, a whole number 1..3999.
//           A value of 0 or above 3999 is taken and dropped with no result.
// numeral : source channel; one transfer per letter (ASCII I V X L C D M),
//           most significant letter first, last set on the final letter.
// Timing: a small control store steps a plain datapath. Each of the four
//   digit positions costs two steps to split off (reciprocal multiply, then
//   subtract and branch on the digit class), each letter costs one step,
//   each digit written as a repeat run costs one more step to leave the run,
//   and one step closes the numeral. number.ready is high only while the
//   sequencer is idle, so one item is in work at a time; the next item can
//   be taken while the final letter still sits in the output register.
//   Each letter waits in a pending register until the next step that writes
//   the output, so last can be set on it once the numeral is known to end.
// Reset: rst clears the sequencer and the output and pending valid flags.
// Stall: while numeral.ready is low and the output register is full, every
//   letter, run-exit and closing step holds; the datapath waits without loss.
module integer_to_roman_numeral (
  input  logic       clk,
  input  logic       rst,
  itrn_in_if.sink    number,
  itrn_out_if.source numeral
);

  itrn_pkg::ctrl_t    ctrl;
  itrn_pkg::status_t  status;
  logic               start;
  logic               in_range;

  // Accept whenever idle; only numbers with a numeral start a run
  assign number.ready = !ctrl.busy;
  assign in_range     = (number.value != '0) && (number.value <= itrn_pkg::VALUE_MAX);
  assign start        = number.valid && number.ready && in_range;

  itrn_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .ctrl   (ctrl)
  );

  itrn_dpath u_dpath (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .value   (number.value),
    .ctrl    (ctrl),
    .status  (status),
    .numeral (numeral)
  );

`ifndef SYNTHESIS
  // Only numeral letters leave the block
  a_letter: assert property (@(posedge clk) disable iff (rst)
    numeral.valid |-> (numeral.symbol == itrn_pkg::CHR_I) || (numeral.symbol == itrn_pkg::CHR_V) ||
                      (numeral.symbol == itrn_pkg::CHR_X) || (numeral.symbol == itrn_pkg::CHR_L) ||
                      (numeral.symbol == itrn_pkg::CHR_C) || (numeral.symbol == itrn_pkg::CHR_D) ||
                      (numeral.symbol == itrn_pkg::CHR_M))
    else $error("non-numeral symbol on output");

  // Going idle always leaves the closing letter in the output register
  a_close: assert property (@(posedge clk) disable iff (rst)
    $fell(ctrl.busy) |-> numeral.valid && numeral.last)
    else $error("sequencer finished without a last letter");

  // The sequencer holds only behind a stalled, full output register
  a_hold: assert property (@(posedge clk) disable iff (rst)
    status.hold |-> numeral.valid && !numeral.ready)
    else $error("sequencer held without output backpressure");
`endif

endmodule
